// File: design/assert_macros.svh
// assertion helpers used by the checker file toh_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is held
`define TOH_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// clocked assertion that also holds across reset
`define TOH_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/toh_pkg.sv
package toh_pkg;

    localparam int TIME_W  = 64;
    localparam int SEQ_W   = 32;
    localparam int DRIVE_W = 16;
    localparam int RUN_W   = 3;
    localparam int AGE_W   = 32;
    localparam int LONG_W  = 15;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [RUN_W-1:0] RUN_ACTIVE   = 3'd0;
    localparam logic [RUN_W-1:0] RUN_DISARMED = 3'd1;
    localparam logic [RUN_W-1:0] RUN_FAULT    = 3'd2;
    localparam logic [RUN_W-1:0] RUN_RETRY    = 3'd3;

    localparam logic [SEQ_W-1:0] SEQ_MAX   = {SEQ_W{1'b1}};
    localparam logic [SEQ_W-1:0] SEQ_FIRST = 32'd1;

    localparam logic [AGE_W-1:0] MAX_AGE_RESET = 32'd100000;

    localparam logic signed [DRIVE_W-1:0] DRIVE_HI = 16'sd16384;
    localparam logic signed [DRIVE_W-1:0] DRIVE_LO = -16'sd16384;

    localparam logic [LONG_W-1:0] LONG_MAX = 15'd16384;

    typedef struct packed {
        logic                      op;
        logic [SEQ_W-1:0]          sequence_number;
        logic [TIME_W-1:0]         event_time;
        logic [TIME_W-1:0]         output_time;
        logic signed [DRIVE_W-1:0] right_drive;
        logic signed [DRIVE_W-1:0] left_drive;
        logic                      drives_finite;
        logic                      drv_ready;
        logic                      cmd_ok;
        logic                      outputs_off;
        logic [RUN_W-1:0]          run_state;
    } t_req;

    typedef struct packed {
        logic [TIME_W-1:0]         stamp;
        logic signed [DRIVE_W-1:0] right_drive;
        logic signed [DRIVE_W-1:0] left_drive;
        logic                      known;
    } t_entry;

    typedef struct packed {
        logic              known;
        logic              seq_break;
        logic              zero_time;
        logic [TIME_W-1:0] stored_time;
    } t_push_info;

    typedef struct packed {
        logic a_lt_b;
        logic gap_over;
    } t_cmp_res;

endpackage

// File: design/toh_req_if.sv
interface toh_req_if;
    logic                                        valid;
    logic                                        ready;
    logic                                        op;
    logic [toh_pkg::SEQ_W-1:0]                   sequence_number;
    logic [toh_pkg::TIME_W-1:0]                  event_time;
    logic [toh_pkg::TIME_W-1:0]                  output_time;
    logic signed [toh_pkg::DRIVE_W-1:0]          right_drive;
    logic signed [toh_pkg::DRIVE_W-1:0]          left_drive;
    logic                                        drives_finite;
    logic                                        drv_ready;
    logic                                        cmd_ok;
    logic                                        outputs_off;
    logic [toh_pkg::RUN_W-1:0]                   run_state;

    modport source (
        output valid, op, sequence_number, event_time, output_time, right_drive,
               left_drive, drives_finite, drv_ready, cmd_ok, outputs_off,
               run_state,
        input  ready
    );

    modport sink (
        input  valid, op, sequence_number, event_time, output_time, right_drive,
               left_drive, drives_finite, drv_ready, cmd_ok, outputs_off,
               run_state,
        output ready
    );
endinterface

// File: design/toh_rsp_if.sv
interface toh_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic [toh_pkg::LONG_W-1:0]   longitudinal;

    modport source (output valid, found, longitudinal, input ready);
    modport sink   (input valid, found, longitudinal, output ready);
endinterface

// File: design/timestamped_output_history_lookup_core.sv
// Output history with time lookup. A push request (op 0) checks the sequence
// number, classifies the status record and stores it in a ring of HISTORY_DEPTH
// entries held in one RAM; a zero stored time empties the ring instead. A query request
// (op 1) walks the ring newest first, one RAM read per cycle through a single
// shared 64-bit subtract/compare unit, examining up to HISTORY_DEPTH entries; an
// empty history answers without a walk. Every query gives one response, a push none.
// The response sits in an output register, so a waiting response does not stop
// the next push; a query finishing behind a stalled response waits for it.
// The ring needs no clearing pass after reset. The user is to write max_age_us
// through i_cfg_wr_en / i_cfg_wr_data only while the block is idle; the block
// itself does not enforce it.
module timestamped_output_history_lookup_core #(
    parameter int HISTORY_DEPTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    toh_req_if.sink                    i_req,
    toh_rsp_if.source                  o_rsp,
    input  logic                       i_cfg_wr_en,
    input  logic [toh_pkg::AGE_W-1:0]  i_cfg_wr_data
);

    localparam int ADDR_W  = $clog2(HISTORY_DEPTH);
    localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
    localparam int ENTRY_W = $bits(toh_pkg::t_entry);
    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(HISTORY_DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(HISTORY_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_PRIME,
        S_WALK,
        S_DONE
    } t_state;

    t_state                        r_state;
    toh_pkg::t_req                 r_req;
    logic [toh_pkg::AGE_W-1:0]     r_max_age;
    logic [ADDR_W-1:0]             r_slot;
    logic [CNT_W-1:0]              r_fill;
    logic [toh_pkg::SEQ_W-1:0]     r_last_seq;
    logic                          r_seen;
    logic [toh_pkg::TIME_W-1:0]    r_newest;
    logic [ADDR_W-1:0]             r_rd_addr;
    logic [CNT_W-1:0]              r_remain;
    logic                          r_res_found;
    logic [toh_pkg::LONG_W-1:0]    r_res_long;
    logic                          r_rsp_valid;
    logic                          r_rsp_found;
    logic [toh_pkg::LONG_W-1:0]    r_rsp_long;

    logic                          req_accept;
    toh_pkg::t_push_info           push_info;
    toh_pkg::t_cmp_res             cmp_res;
    logic [toh_pkg::TIME_W-1:0]    cmp_a;
    logic [toh_pkg::TIME_W-1:0]    cmp_b;
    logic [ENTRY_W-1:0]            rd_data;
    toh_pkg::t_entry               rd_entry;
    toh_pkg::t_entry               wr_entry;
    logic [CNT_W-1:0]              fill_eff;
    logic                          backwards;
    logic [CNT_W-1:0]              n_fill_base;
    logic [ADDR_W-1:0]             slot_base;
    logic [ADDR_W-1:0]             n_slot;
    logic [CNT_W-1:0]              n_fill;
    logic [ADDR_W-1:0]             newest_slot;
    logic [ADDR_W-1:0]             prev_addr;
    logic                          push_we;
    logic [toh_pkg::DRIVE_W:0]     drive_sum;
    logic                          hit_ok;

    assign i_req.ready = (r_state == S_IDLE);
    assign req_accept  = i_req.valid && i_req.ready;

    toh_push_eval u_push_eval (
        .i_req      (r_req),
        .i_last_seq (r_last_seq),
        .i_seen     (r_seen),
        .o_info     (push_info)
    );

    // one comparator serves the backwards check of a push and every query step
    assign cmp_a = (r_state == S_PUSH) ? push_info.stored_time : r_req.event_time;
    assign cmp_b = (r_state == S_PUSH) ? r_newest : rd_entry.stamp;

    toh_cmp u_cmp (
        .i_a     (cmp_a),
        .i_b     (cmp_b),
        .i_limit (r_max_age),
        .o_res   (cmp_res)
    );

    // a sequence gap empties the ring before the backwards check looks at it
    assign fill_eff    = push_info.seq_break ? '0 : r_fill;
    assign backwards   = (fill_eff != '0) && cmp_res.a_lt_b;
    assign n_fill_base = backwards ? '0 : fill_eff;
    assign slot_base   = (push_info.seq_break || backwards) ? '0 : r_slot;
    assign n_slot      = (slot_base == LAST_SLOT) ? '0 : slot_base + ADDR_W'(1);
    assign n_fill      = (n_fill_base == FULL_CNT) ? FULL_CNT : n_fill_base + CNT_W'(1);
    assign push_we     = (r_state == S_PUSH) && !push_info.zero_time;

    assign wr_entry.stamp       = push_info.stored_time;
    assign wr_entry.right_drive = r_req.right_drive;
    assign wr_entry.left_drive  = r_req.left_drive;
    assign wr_entry.known       = push_info.known;

    assign newest_slot = (r_slot == '0) ? LAST_SLOT : r_slot - ADDR_W'(1);
    assign prev_addr   = (r_rd_addr == '0) ? LAST_SLOT : r_rd_addr - ADDR_W'(1);

    toh_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (push_we),
        .i_waddr (slot_base),
        .i_wdata (wr_entry),
        .i_raddr (r_rd_addr),
        .o_rdata (rd_data)
    );

    assign rd_entry = toh_pkg::t_entry'(rd_data);

    assign drive_sum = {rd_entry.right_drive[toh_pkg::DRIVE_W-1], rd_entry.right_drive}
                     + {rd_entry.left_drive[toh_pkg::DRIVE_W-1], rd_entry.left_drive};
    assign hit_ok = rd_entry.known && !cmp_res.gap_over
                 && !rd_entry.right_drive[toh_pkg::DRIVE_W-1]
                 && !rd_entry.left_drive[toh_pkg::DRIVE_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max_age   <= toh_pkg::MAX_AGE_RESET;
            r_slot      <= '0;
            r_fill      <= '0;
            r_last_seq  <= '0;
            r_seen      <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_age <= i_cfg_wr_data;
            end
            // a finishing query reloads the response register itself
            if (r_rsp_valid && o_rsp.ready && (r_state != S_DONE)) begin
                r_rsp_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (req_accept) begin
                        r_req.op              <= i_req.op;
                        r_req.sequence_number <= i_req.sequence_number;
                        r_req.event_time      <= i_req.event_time;
                        r_req.output_time     <= i_req.output_time;
                        r_req.right_drive     <= i_req.right_drive;
                        r_req.left_drive      <= i_req.left_drive;
                        r_req.drives_finite   <= i_req.drives_finite;
                        r_req.drv_ready       <= i_req.drv_ready;
                        r_req.cmd_ok          <= i_req.cmd_ok;
                        r_req.outputs_off     <= i_req.outputs_off;
                        r_req.run_state       <= i_req.run_state;
                        if (i_req.op == toh_pkg::OP_QUERY) begin
                            r_rd_addr <= newest_slot;
                            r_remain  <= r_fill;
                            if (r_fill == '0) begin
                                r_res_found <= 1'b0;
                                r_res_long  <= '0;
                                r_state     <= S_DONE;
                            end else begin
                                r_state <= S_PRIME;
                            end
                        end else begin
                            r_state <= S_PUSH;
                        end
                    end
                end
                S_PUSH: begin
                    r_last_seq <= r_req.sequence_number;
                    if (push_info.zero_time) begin
                        r_slot <= '0;
                        r_fill <= '0;
                        r_seen <= 1'b0;
                    end else begin
                        r_slot   <= n_slot;
                        r_fill   <= n_fill;
                        r_seen   <= !backwards;
                        r_newest <= push_info.stored_time;
                    end
                    r_state <= S_IDLE;
                end
                S_PRIME: begin
                    // ram is now reading the newest entry; point at the next older one
                    r_rd_addr <= prev_addr;
                    r_state   <= S_WALK;
                end
                S_WALK: begin
                    if (cmp_res.a_lt_b) begin
                        // entry later than the query time, skip it
                        if (r_remain == CNT_W'(1)) begin
                            r_res_found <= 1'b0;
                            r_res_long  <= '0;
                            r_state     <= S_DONE;
                        end else begin
                            r_remain  <= r_remain - CNT_W'(1);
                            r_rd_addr <= prev_addr;
                        end
                    end else begin
                        r_res_found <= hit_ok;
                        r_res_long  <= hit_ok ? drive_sum[toh_pkg::LONG_W:1] : '0;
                        r_state     <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_rsp_valid || o_rsp.ready) begin
                        r_rsp_valid <= 1'b1;
                        r_rsp_found <= r_res_found;
                        r_rsp_long  <= r_res_long;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid        = r_rsp_valid;
    assign o_rsp.found        = r_rsp_found;
    assign o_rsp.longitudinal = r_rsp_long;

endmodule

// File: design/toh_ram.sv
module toh_ram #(
    parameter int WIDTH = 97,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/toh_push_eval.sv
module toh_push_eval (
    input  toh_pkg::t_req                   i_req,
    input  logic [toh_pkg::SEQ_W-1:0]       i_last_seq,
    input  logic                            i_seen,
    output toh_pkg::t_push_info             o_info
);

    logic [toh_pkg::SEQ_W-1:0] expected;
    logic                      mode_ok;
    logic                      drives_ok;
    logic                      known;

    // all-ones wraps to 1, not 0
    assign expected = (i_last_seq == toh_pkg::SEQ_MAX) ? toh_pkg::SEQ_FIRST
                                                       : i_last_seq + toh_pkg::SEQ_FIRST;

    assign mode_ok = ((i_req.run_state == toh_pkg::RUN_ACTIVE) && i_req.cmd_ok)
                  || (i_req.run_state == toh_pkg::RUN_DISARMED)
                  || (i_req.outputs_off && (i_req.run_state != toh_pkg::RUN_FAULT)
                      && (i_req.run_state != toh_pkg::RUN_RETRY));

    assign drives_ok = (i_req.right_drive >= toh_pkg::DRIVE_LO)
                    && (i_req.right_drive <= toh_pkg::DRIVE_HI)
                    && (i_req.left_drive >= toh_pkg::DRIVE_LO)
                    && (i_req.left_drive <= toh_pkg::DRIVE_HI);

    assign known = i_req.drv_ready && (i_req.output_time != '0)
                && (i_req.output_time <= i_req.event_time)
                && i_req.drives_finite && drives_ok && mode_ok;

    assign o_info.known       = known;
    assign o_info.seq_break   = i_seen && (i_req.sequence_number != expected);
    assign o_info.stored_time = known ? i_req.output_time : i_req.event_time;
    assign o_info.zero_time   = (o_info.stored_time == '0);

endmodule

// File: design/toh_cmp.sv
module toh_cmp (
    input  logic [toh_pkg::TIME_W-1:0] i_a,
    input  logic [toh_pkg::TIME_W-1:0] i_b,
    input  logic [toh_pkg::AGE_W-1:0]  i_limit,
    output toh_pkg::t_cmp_res          o_res
);

    logic [toh_pkg::TIME_W:0] diff;

    // borrow out of a - b tells a < b; the difference feeds the age check
    assign diff = {1'b0, i_a} - {1'b0, i_b};

    assign o_res.a_lt_b   = diff[toh_pkg::TIME_W];
    assign o_res.gap_over = !diff[toh_pkg::TIME_W]
                         && (diff[toh_pkg::TIME_W-1:0]
                             > {{(toh_pkg::TIME_W-toh_pkg::AGE_W){1'b0}}, i_limit});

endmodule

// File: design/toh_checker.sv
`include "assert_macros.svh"

module toh_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_req_valid,
    input logic                        i_req_ready,
    input logic                        i_req_op,
    input logic                        i_rsp_valid,
    input logic                        i_rsp_ready,
    input logic                        i_rsp_found,
    input logic [toh_pkg::LONG_W-1:0]  i_rsp_longitudinal
);

    `TOH_ASSERT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_found) && $stable(i_rsp_longitudinal), "stalled response changed")
    `TOH_ASSERT(a_miss_zero, i_clk, i_rst_n, i_rsp_valid && !i_rsp_found |-> i_rsp_longitudinal == '0, "miss with nonzero output")
    `TOH_ASSERT(a_mean_range, i_clk, i_rst_n, i_rsp_valid && i_rsp_found |-> i_rsp_longitudinal <= toh_pkg::LONG_MAX, "mean out of range")
    `TOH_ASSERT(a_query_busy, i_clk, i_rst_n, i_req_valid && i_req_ready && (i_req_op == toh_pkg::OP_QUERY) |=> !i_req_ready, "ready right after query")
    `TOH_ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !i_rsp_valid, "response valid after reset")

endmodule

bind timestamped_output_history_lookup_core toh_checker u_toh_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_req_valid        (i_req.valid),
    .i_req_ready        (i_req.ready),
    .i_req_op           (i_req.op),
    .i_rsp_valid        (o_rsp.valid),
    .i_rsp_ready        (o_rsp.ready),
    .i_rsp_found        (o_rsp.found),
    .i_rsp_longitudinal (o_rsp.longitudinal)
);

// File: tb/toh_history_checker.sv
`timescale 1ns / 100ps
module toh_history_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    toh_req_if                        i_req_mon,
    toh_rsp_if                        i_rsp_mon,
    input  logic                      i_cfg_wr_en,
    input  logic [toh_pkg::AGE_W-1:0] i_cfg_wr_data,
    output int unsigned               o_mismatches,
    output int unsigned               o_pending,
    output int unsigned               o_pushes,
    output int unsigned               o_queries,
    output int unsigned               o_hits
);

    localparam int DEPTH = 32;

    typedef struct packed {
        logic                       found;
        logic [toh_pkg::LONG_W-1:0] longitudinal;
    } t_answer;

    logic [toh_pkg::TIME_W-1:0]         hist_time  [DEPTH];
    logic signed [toh_pkg::DRIVE_W-1:0] hist_right [DEPTH];
    logic signed [toh_pkg::DRIVE_W-1:0] hist_left  [DEPTH];
    logic                               hist_known [DEPTH];
    logic [4:0]                         next_slot;
    int unsigned                        depth_used;
    logic [toh_pkg::SEQ_W-1:0]          prev_seq;
    logic                               seq_valid;
    logic [toh_pkg::AGE_W-1:0]          age_limit;
    t_answer                            answers_due[$];

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s, got %0d, want %0d", $time, what, got, want);
        o_mismatches++;
    endtask

    function automatic void forget_history();
        next_slot  = '0;
        depth_used = 0;
        seq_valid  = 1'b0;
    endfunction

    function automatic void store_status(input toh_pkg::t_req r);
        logic [toh_pkg::SEQ_W-1:0]  follow;
        logic                       mode_ok;
        logic                       known;
        logic [toh_pkg::TIME_W-1:0] stamp;
        follow = (prev_seq == toh_pkg::SEQ_MAX) ? toh_pkg::SEQ_FIRST : prev_seq + 1'b1;
        if (seq_valid && r.sequence_number != follow) begin
            forget_history();
        end
        prev_seq  = r.sequence_number;
        seq_valid = 1'b1;

        mode_ok = (r.run_state == toh_pkg::RUN_ACTIVE && r.cmd_ok) ||
                  r.run_state == toh_pkg::RUN_DISARMED ||
                  (r.outputs_off && r.run_state != toh_pkg::RUN_FAULT &&
                   r.run_state != toh_pkg::RUN_RETRY);
        known = r.drv_ready && r.output_time != '0 && r.output_time <= r.event_time &&
                r.drives_finite &&
                r.right_drive >= toh_pkg::DRIVE_LO && r.right_drive <= toh_pkg::DRIVE_HI &&
                r.left_drive >= toh_pkg::DRIVE_LO && r.left_drive <= toh_pkg::DRIVE_HI &&
                mode_ok;
        stamp = known ? r.output_time : r.event_time;

        if (stamp == '0) begin
            forget_history();
        end else begin
            // time going backwards drops everything older, then stores
            if (depth_used != 0 && stamp < hist_time[5'(next_slot - 5'd1)]) begin
                forget_history();
            end
            hist_time[next_slot]  = stamp;
            hist_right[next_slot] = r.right_drive;
            hist_left[next_slot]  = r.left_drive;
            hist_known[next_slot] = known;
            next_slot = next_slot + 5'd1;
            if (depth_used < DEPTH) begin
                depth_used++;
            end
        end
    endfunction

    function automatic t_answer answer_query(input logic [toh_pkg::TIME_W-1:0] q);
        t_answer    a;
        logic [4:0] idx;
        int         sum;
        bit         decided;
        a       = '0;
        decided = 1'b0;
        // newest first; the first entry not later than q decides
        for (int age = 0; age < int'(depth_used) && !decided; age++) begin
            idx = 5'(next_slot - 5'd1 - 5'(age));
            if (hist_time[idx] <= q) begin
                decided = 1'b1;
                if (hist_known[idx] && (q - hist_time[idx]) <= {32'd0, age_limit} &&
                    hist_right[idx] >= 0 && hist_left[idx] >= 0) begin
                    sum = int'(hist_right[idx]) + int'(hist_left[idx]);
                    a.found        = 1'b1;
                    a.longitudinal = toh_pkg::LONG_W'(sum / 2);
                end
            end
        end
        return a;
    endfunction

    always @(posedge i_clk) begin
        toh_pkg::t_req seen;
        t_answer       want;
        if (!i_rst_n) begin
            forget_history();
            prev_seq     = '0;
            age_limit    = toh_pkg::MAX_AGE_RESET;
            answers_due.delete();
            o_mismatches = 0;
            o_pushes     = 0;
            o_queries    = 0;
            o_hits       = 0;
        end else begin
            if (i_cfg_wr_en) begin
                age_limit = i_cfg_wr_data;
            end

            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                if (answers_due.size() == 0) begin
                    report_mismatch("response with no query waiting",
                                    64'(i_rsp_mon.longitudinal), 64'd0);
                end else begin
                    want = answers_due.pop_front();
                    if (i_rsp_mon.found !== want.found) begin
                        report_mismatch("found", 64'(i_rsp_mon.found), 64'(want.found));
                    end
                    if (i_rsp_mon.longitudinal !== want.longitudinal) begin
                        report_mismatch("longitudinal", 64'(i_rsp_mon.longitudinal),
                                        64'(want.longitudinal));
                    end
                end
            end

            if (i_req_mon.valid && i_req_mon.ready) begin
                seen = '{op:              i_req_mon.op,
                         sequence_number: i_req_mon.sequence_number,
                         event_time:      i_req_mon.event_time,
                         output_time:     i_req_mon.output_time,
                         right_drive:     i_req_mon.right_drive,
                         left_drive:      i_req_mon.left_drive,
                         drives_finite:   i_req_mon.drives_finite,
                         drv_ready:       i_req_mon.drv_ready,
                         cmd_ok:          i_req_mon.cmd_ok,
                         outputs_off:     i_req_mon.outputs_off,
                         run_state:       i_req_mon.run_state};
                if (seen.op == toh_pkg::OP_QUERY) begin
                    want = answer_query(seen.event_time);
                    answers_due.push_back(want);
                    o_queries++;
                    if (want.found) begin
                        o_hits++;
                    end
                end else begin
                    store_status(seen);
                    o_pushes++;
                end
            end
        end
        o_pending = answers_due.size();
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
module testbench;

    localparam int                        SEGMENTS      = 6;
    localparam int                        SEG_ITEMS     = 150;
    localparam int                        SETTLE_CYCLES = 40;
    localparam int                        HOLD_CYCLES   = 400;
    localparam int                        QUIET_LIMIT   = 6000;
    localparam logic [toh_pkg::RUN_W-1:0] RUN_OTHER     = 3'd7;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_wr_en;
    logic [toh_pkg::AGE_W-1:0]  cfg_wr_data;

    int unsigned                src_idle_pct;
    int unsigned                snk_idle_pct;
    bit                         hold_armed;
    int unsigned                quiet_cycles;

    // stimulus-side view of the sequence and time line
    logic [toh_pkg::SEQ_W-1:0]  gen_seq;
    logic [toh_pkg::TIME_W-1:0] gen_event;
    logic [toh_pkg::TIME_W-1:0] last_stamp;
    logic [toh_pkg::AGE_W-1:0]  cur_age;

    int unsigned                mismatches;
    int unsigned                pending;
    int unsigned                pushes;
    int unsigned                queries;
    int unsigned                hits;

    toh_req_if req_ch ();
    toh_rsp_if rsp_ch ();

    timestamped_output_history_lookup_core uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req         (req_ch),
        .o_rsp         (rsp_ch),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    toh_history_checker history_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req_mon     (req_ch),
        .i_rsp_mon     (rsp_ch),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .o_mismatches  (mismatches),
        .o_pending     (pending),
        .o_pushes      (pushes),
        .o_queries     (queries),
        .o_hits        (hits)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no request or response moved for %0d cycles", quiet_cycles);
            $display("FAIL timestamped_output_history_lookup_core");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // response side: random stalls, plus one long hold-off when armed
    initial begin
        int unsigned hold_left;
        bit          hold_used;
        hold_left    = 0;
        hold_used    = 1'b0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_armed && !hold_used) begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    task automatic offer(input toh_pkg::t_req it);
        while ($urandom_range(99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.op              <= it.op;
        req_ch.sequence_number <= it.sequence_number;
        req_ch.event_time      <= it.event_time;
        req_ch.output_time     <= it.output_time;
        req_ch.right_drive     <= it.right_drive;
        req_ch.left_drive      <= it.left_drive;
        req_ch.drives_finite   <= it.drives_finite;
        req_ch.drv_ready       <= it.drv_ready;
        req_ch.cmd_ok          <= it.cmd_ok;
        req_ch.outputs_off     <= it.outputs_off;
        req_ch.run_state       <= it.run_state;
        req_ch.valid           <= 1'b1;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    // stop offering, let every answer come back and the last push finish
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_max_age(input logic [toh_pkg::AGE_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        cur_age      = value;
    endtask

    function automatic toh_pkg::t_req noise_fields();
        toh_pkg::t_req it;
        it.op              = toh_pkg::OP_PUSH;
        it.sequence_number = $urandom;
        it.event_time      = {$urandom, $urandom};
        it.output_time     = {$urandom, $urandom};
        it.right_drive     = toh_pkg::DRIVE_W'($urandom);
        it.left_drive      = toh_pkg::DRIVE_W'($urandom);
        it.drives_finite   = 1'($urandom);
        it.drv_ready       = 1'($urandom);
        it.cmd_ok          = 1'($urandom);
        it.outputs_off     = 1'($urandom);
        it.run_state       = toh_pkg::RUN_W'($urandom);
        return it;
    endfunction

    function automatic toh_pkg::t_req status(input logic [toh_pkg::SEQ_W-1:0] seq,
                                             input logic [toh_pkg::TIME_W-1:0] ev,
                                             input logic [toh_pkg::TIME_W-1:0] ot,
                                             input logic signed [toh_pkg::DRIVE_W-1:0] r,
                                             input logic signed [toh_pkg::DRIVE_W-1:0] l,
                                             input logic [toh_pkg::RUN_W-1:0] run,
                                             input logic cmd, input logic soff);
        toh_pkg::t_req it;
        it = '{op: toh_pkg::OP_PUSH, sequence_number: seq, event_time: ev, output_time: ot,
               right_drive: r, left_drive: l, drives_finite: 1'b1, drv_ready: 1'b1,
               cmd_ok: cmd, outputs_off: soff, run_state: run};
        return it;
    endfunction

    function automatic toh_pkg::t_req lookup(input logic [toh_pkg::TIME_W-1:0] at);
        toh_pkg::t_req it;
        it            = noise_fields();
        it.op         = toh_pkg::OP_QUERY;
        it.event_time = at;
        return it;
    endfunction

    function automatic toh_pkg::t_req make_random_item();
        toh_pkg::t_req             it;
        int unsigned               pick;
        int unsigned               near;
        logic [toh_pkg::SEQ_W-1:0] follow;
        it     = noise_fields();
        pick   = $urandom_range(99);
        near   = (cur_age > 50000) ? 50000 : cur_age;
        follow = (gen_seq == toh_pkg::SEQ_MAX) ? toh_pkg::SEQ_FIRST : gen_seq + 1'b1;
        if (pick < 38) begin
            it.op = toh_pkg::OP_QUERY;
            case ($urandom_range(9))
                0, 1, 2, 3: it.event_time = last_stamp + 64'($urandom_range(0, near));
                4:          it.event_time = last_stamp;
                5:          it.event_time = last_stamp + 64'(cur_age) + 64'($urandom_range(0, 2));
                6, 7:       it.event_time = last_stamp - 64'($urandom_range(1, 5000));
                8:          it.event_time = '0;
                default: ;
            endcase
        end else if (pick < 92) begin
            it.sequence_number = follow;
            it.event_time      = gen_event + 64'($urandom_range(1, 3000));
            it.output_time     = it.event_time - 64'($urandom_range(0, 800));
            if ($urandom_range(3) != 0) begin
                it.right_drive = toh_pkg::DRIVE_W'($urandom_range(0, 16384));
                it.left_drive  = toh_pkg::DRIVE_W'($urandom_range(0, 16384));
            end else begin
                it.right_drive = toh_pkg::DRIVE_W'(int'($urandom_range(0, 32768)) - 16384);
                it.left_drive  = toh_pkg::DRIVE_W'(int'($urandom_range(0, 32768)) - 16384);
            end
            it.drives_finite = 1'b1;
            it.drv_ready     = 1'b1;
            if ($urandom_range(2) != 0) begin
                it.run_state = toh_pkg::RUN_ACTIVE;
                it.cmd_ok    = 1'b1;
            end
            // now and then spoil one condition of a known record
            case ($urandom_range(11))
                0: it.drv_ready     = 1'b0;
                1: it.drives_finite = 1'b0;
                2: it.output_time   = '0;
                3: it.output_time   = it.event_time + 64'($urandom_range(1, 50));
                4: it.right_drive   = toh_pkg::DRIVE_W'(16384 + $urandom_range(1, 16383));
                default: ;
            endcase
        end else begin
            case ($urandom_range(3))
                0: begin
                    it.sequence_number = gen_seq + 32'($urandom_range(2, 1000));
                    it.event_time      = gen_event + 64'($urandom_range(1, 3000));
                    it.output_time     = it.event_time;
                end
                1: begin
                    it.sequence_number = follow;
                    it.event_time      = '0;
                end
                2: begin
                    it.sequence_number = follow;
                    it.event_time      = gen_event - 64'($urandom_range(1, 20000));
                    it.output_time     = it.event_time - 64'($urandom_range(0, 800));
                end
                default: begin
                    it.output_time = it.event_time - 64'($urandom_range(0, 800));
                end
            endcase
        end
        if (it.op == toh_pkg::OP_PUSH) begin
            gen_seq    = it.sequence_number;
            gen_event  = it.event_time;
            last_stamp = (it.output_time != '0 && it.output_time <= it.event_time) ?
                         it.output_time : it.event_time;
        end
        return it;
    endfunction

    initial begin
        toh_pkg::t_req it;
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        hold_armed   = 1'b0;
        cur_age      = toh_pkg::MAX_AGE_RESET;
        src_idle_pct = 28;
        snk_idle_pct = 71;
        req_ch.valid = 1'b0;
        {req_ch.op, req_ch.sequence_number, req_ch.event_time, req_ch.output_time,
         req_ch.right_drive, req_ch.left_drive, req_ch.drives_finite, req_ch.drv_ready,
         req_ch.cmd_ok, req_ch.outputs_off, req_ch.run_state} = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty history, age boundary, odd sum, negative output
        offer(lookup(64'd500));
        offer(status(32'd5, 64'd1000, 64'd900, toh_pkg::DRIVE_HI, toh_pkg::DRIVE_HI,
                     toh_pkg::RUN_ACTIVE, 1'b1, 1'b0));
        offer(lookup(64'd0));
        offer(lookup(64'd900));
        offer(lookup(64'd900 + 64'(toh_pkg::MAX_AGE_RESET)));
        offer(lookup(64'd901 + 64'(toh_pkg::MAX_AGE_RESET)));
        offer(status(32'd6, 64'd2000, 64'd2000, 16'sd3, 16'sd0, toh_pkg::RUN_DISARMED,
                     1'b0, 1'b0));
        offer(lookup(64'd2000));
        offer(status(32'd7, 64'd3000, 64'd2990, -16'sd1, 16'sd100, toh_pkg::RUN_ACTIVE,
                     1'b1, 1'b0));
        offer(lookup(64'd3000));
        // unknown records: no output time, output after publish, out of range, not finite
        offer(status(32'd8, 64'd4000, 64'd0, 16'sd10, 16'sd10, toh_pkg::RUN_FAULT,
                     1'b1, 1'b1));
        offer(lookup(64'd4000));
        offer(status(32'd9, 64'd5000, 64'd5001, 16'sd16385, 16'sd0, toh_pkg::RUN_RETRY,
                     1'b1, 1'b1));
        it = status(32'd10, 64'd6000, 64'd6000, 16'sd20, 16'sd20, toh_pkg::RUN_ACTIVE,
                    1'b1, 1'b0);
        it.drives_finite = 1'b0;
        offer(it);
        offer(status(32'd11, 64'd7000, 64'd6990, 16'sd200, 16'sd100, RUN_OTHER, 1'b0, 1'b1));
        offer(lookup(64'd7000));
        offer(lookup(64'd6500));
        // zero time clears; then sequence wrap, gap and time going backwards
        offer(status(32'd12, 64'd0, 64'd0, 16'sd0, 16'sd0, toh_pkg::RUN_ACTIVE, 1'b1, 1'b0));
        offer(lookup(64'd7000));
        offer(status(toh_pkg::SEQ_MAX, 64'd8000, 64'd8000, 16'sd0, 16'sd0,
                     toh_pkg::RUN_ACTIVE, 1'b1, 1'b0));
        offer(status(toh_pkg::SEQ_FIRST, 64'd9000, 64'd8500, toh_pkg::DRIVE_HI, 16'sd0,
                     toh_pkg::RUN_DISARMED, 1'b0, 1'b0));
        offer(lookup(64'd8600));
        offer(status(32'd5, 64'd9500, 64'd9500, 16'sd100, 16'sd100, toh_pkg::RUN_ACTIVE,
                     1'b1, 1'b0));
        offer(lookup(64'd8800));
        offer(status(32'd6, 64'd9400, 64'd9400, 16'sd50, 16'sd50, toh_pkg::RUN_ACTIVE,
                     1'b1, 1'b0));
        offer(lookup(64'd9600));
        offer(status(32'd7, '1, '1, 16'sh7fff, 16'sh8000, toh_pkg::RUN_ACTIVE, 1'b1, 1'b0));
        offer(lookup('1));
        drain();

        gen_seq    = 32'd100;
        gen_event  = 64'd20000;
        last_stamp = 64'd20000;
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg / 2)
                0: begin
                    src_idle_pct = 28;
                    snk_idle_pct = 71;
                end
                1: begin
                    src_idle_pct = 71;
                    snk_idle_pct = 28;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            case (seg)
                1:       write_max_age('0);
                2:       write_max_age('1);
                3:       write_max_age(toh_pkg::AGE_W'($urandom_range(1000, 200000)));
                4:       write_max_age(32'd1);
                5:       write_max_age(toh_pkg::MAX_AGE_RESET);
                default: ;
            endcase
            if (seg == 4) begin
                // hold responses off while requests keep coming
                @(posedge clk);
                hold_armed = 1'b1;
                @(negedge clk);
            end
            for (int n = 0; n < SEG_ITEMS; n++) begin
                offer(make_random_item());
            end
            drain();
        end

        $display("covered %0d status pushes and %0d lookups, %0d of which found an output",
                 pushes, queries, hits);
        $display("max age went through reset, zero, all ones, one and a random value");
        if (mismatches == 0 && pending == 0) begin
            $display("PASS timestamped_output_history_lookup_core");
        end else begin
            $display("FAIL timestamped_output_history_lookup_core");
        end
        $finish;
    end

endmodule
